// ===== rtl/cma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

	localparam int MAX_TAPS    = 7;
	localparam int SAMPLE_BITS = 16;

	localparam int WIN_BITS  = 3;
	localparam int TAP_BITS  = $clog2(MAX_TAPS + 1);
	localparam int HALF_BITS = $clog2(MAX_TAPS / 2 + 1);
	localparam int POS_BITS  = $clog2(MAX_TAPS + 1);
	localparam int CNT_BITS  = 3;
	localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_TAPS);

	localparam int RECIP_SHIFT = SUM_BITS + 1;
	localparam int RECIP_BITS  = RECIP_SHIFT;
	localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

	localparam logic [WIN_BITS-1:0]   WIN_RESET  = WIN_BITS'(3);
	localparam logic [HALF_BITS-1:0]  HALF_RESET = HALF_BITS'(1);
	localparam logic [TAP_BITS-1:0]   TAP_TOP    = TAP_BITS'(MAX_TAPS - 1 + MAX_TAPS % 2);
	localparam logic [RECIP_BITS-1:0] RECIP3     = RECIP_BITS'((1 << RECIP_SHIFT) / 3);
	localparam logic [RECIP_BITS-1:0] RECIP5     = RECIP_BITS'((1 << RECIP_SHIFT) / 5);
	localparam logic [RECIP_BITS-1:0] RECIP7     = RECIP_BITS'((1 << RECIP_SHIFT) / 7);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_FIX,
		ST_OUT
	} cma_state_t;

	typedef struct packed {
		logic load;
		logic sum_en;
		logic div_en;
		logic fix_en;
		logic lead;
		logic final_word;
	} cma_cmd_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] word_count;
		logic                block_last;
	} cma_status_t;

	// Half of the odd tap count rounded up from the register, kept between 3 and the top odd value.
	function automatic logic [HALF_BITS-1:0] half_of(input logic [WIN_BITS-1:0] win);
		logic [TAP_BITS-1:0] taps;
		taps = TAP_BITS'(win) | TAP_BITS'(1);
		if (taps < TAP_BITS'(3))
			taps = TAP_BITS'(3);
		if (taps > TAP_TOP)
			taps = TAP_TOP;
		return HALF_BITS'(taps >> 1);
	endfunction

	function automatic logic [RECIP_BITS-1:0] recip_of(input logic [HALF_BITS-1:0] half);
		logic [RECIP_BITS-1:0] r;
		case (half)
			HALF_BITS'(1): r = RECIP3;
			HALF_BITS'(2): r = RECIP5;
			default:       r = RECIP7;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/cma_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cma_sample_if import cma_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          block_end;

	modport source (output valid, output sample, output block_end, input ready);
	modport sink (input valid, input sample, input block_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/cma_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cma_result_if import cma_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] average;
	logic                          final_res;

	modport source (output valid, output average, output final_res, input ready);
	modport sink (input valid, input average, input final_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/cma_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cma_datapath import cma_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [WIN_BITS-1:0]           cfg_wdata,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic                          block_end,
	input  wire cma_cmd_t                      cmd,
	output cma_status_t                        status,
	output logic signed [SAMPLE_BITS-1:0]      average
);

	logic [WIN_BITS-1:0]           window_q;
	logic [POS_BITS-1:0]           pos_q;
	logic [HALF_BITS-1:0]          half_q;
	logic [CNT_BITS-1:0]           count_q;
	logic                          use_avg_q;
	logic                          last_q;
	logic signed [SAMPLE_BITS-1:0] line_q [MAX_TAPS];
	logic [SUM_BITS-1:0]           mag_q;
	logic                          neg_q;
	logic [PROD_BITS-1:0]          prod_q;
	logic signed [SAMPLE_BITS-1:0] avg_q;

	logic [HALF_BITS-1:0]          half_d;
	logic [CNT_BITS-1:0]           count_d;
	logic [TAP_BITS-1:0]           taps;
	logic signed [SUM_BITS-1:0]    sum;
	logic [SUM_BITS-1:0]           q0;
	logic [SUM_BITS+TAP_BITS-1:0]  back;
	logic [SUM_BITS+TAP_BITS-1:0]  rem;
	logic [SUM_BITS-1:0]           quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// The half window is taken from the register only at the first sample of a block.
	always_comb begin
		half_d = (pos_q == '0) ? half_of(window_q) : half_q;
		if (pos_q >= POS_BITS'(half_d))
			count_d = CNT_BITS'(1) + (block_end ? CNT_BITS'(half_d) : '0);
		else
			count_d = block_end ? CNT_BITS'(pos_q) + CNT_BITS'(1) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			half_q    <= HALF_RESET;
			count_q   <= '0;
			use_avg_q <= 1'b0;
			last_q    <= 1'b0;
		end else if (cmd.load) begin
			half_q    <= half_d;
			count_q   <= count_d;
			use_avg_q <= pos_q >= POS_BITS'({half_d, 1'b0});
			last_q    <= block_end;
			if (block_end)
				pos_q <= '0;
			else if (pos_q < POS_BITS'(MAX_TAPS))
				pos_q <= pos_q + POS_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			line_q[0] <= sample;
			for (int k = 1; k < MAX_TAPS; k++)
				line_q[k] <= line_q[k-1];
		end
	end

	always_comb begin
		taps = TAP_BITS'({half_q, 1'b1});
		sum  = '0;
		for (int k = 0; k < MAX_TAPS; k++) begin
			if (TAP_BITS'(k) < taps)
				sum = sum + SUM_BITS'(line_q[k]);
		end
	end

	// Division by 3, 5 or 7: reciprocal multiply gives the quotient or one less,
	// and a single compare against the remainder fixes it.
	always_comb begin
		q0   = prod_q[PROD_BITS-1:RECIP_SHIFT];
		back = (SUM_BITS+TAP_BITS)'(q0) * (SUM_BITS+TAP_BITS)'(taps);
		rem  = (SUM_BITS+TAP_BITS)'(mag_q) - back;
		quot = (rem >= (SUM_BITS+TAP_BITS)'(taps)) ? q0 + SUM_BITS'(1) : q0;
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			neg_q <= sum[SUM_BITS-1];
			mag_q <= sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
		end
		if (cmd.div_en)
			prod_q <= PROD_BITS'(mag_q) * PROD_BITS'(recip_of(half_q));
		if (cmd.fix_en)
			avg_q <= neg_q ? SAMPLE_BITS'(-quot) : SAMPLE_BITS'(quot);
	end

	assign status.word_count = count_q;
	assign status.block_last = last_q;
	assign average = (cmd.lead && use_avg_q) ? avg_q : '0;

endmodule

`default_nettype wire

// ===== rtl/cma_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cma_controller import cma_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire cma_status_t status,
	output cma_cmd_t         cmd
);

	cma_state_t          state_q, state_d;
	logic [CNT_BITS-1:0] rem_q, rem_d;
	logic                lead_q, lead_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
			lead_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rem_q   <= rem_d;
			lead_q  <= lead_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		rem_d          = rem_q;
		lead_d         = lead_q;
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		cmd            = '0;
		cmd.lead       = lead_q;
		// Only the last word of a sample that closes its block carries the flag.
		cmd.final_word = (rem_q == CNT_BITS'(1)) && status.block_last;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = (status.word_count == '0) ? ST_IDLE : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_en = 1'b1;
				state_d    = ST_FIX;
			end
			ST_FIX: begin
				cmd.fix_en = 1'b1;
				rem_d      = status.word_count;
				lead_d     = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					rem_d  = rem_q - CNT_BITS'(1);
					lead_d = 1'b0;
					if (rem_q == CNT_BITS'(1))
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/centered_moving_average_top.sv =====
// The first word of a sample is offered once the sum, reciprocal multiply and correction
// steps of the divide path are done. One sample at a time: a new sample is taken only after
// the last one has left the sum step, if it yields no word, else after all its words (up
// to four) were taken by the receiver, which can stall each word.
// Reset clears the controller, the block position, the half window (one) and the
// window register (three taps).
`timescale 1ns / 1ps
`default_nettype none

module centered_moving_average_top import cma_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [WIN_BITS-1:0] cfg_wdata,
	cma_sample_if.sink               samples,
	cma_result_if.source             results
);

	cma_cmd_t    cmd;
	cma_status_t status;
	logic        in_ready;
	logic        out_valid;

	cma_controller u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	cma_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample    (samples.sample),
		.block_end (samples.block_end),
		.cmd       (cmd),
		.status    (status),
		.average   (results.average)
	);

	assign samples.ready     = in_ready;
	assign results.valid     = out_valid;
	assign results.final_res = cmd.final_word;

endmodule

`default_nettype wire

// ===== tb/cma_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cma_checker import cma_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [WIN_BITS-1:0] cfg_wdata,
	cma_sample_if                    samples,
	cma_result_if                    results,
	output int                       mismatch_count,
	output int                       words_pending
);

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] average;
		logic                          final_res;
	} avg_word_t;

	logic signed [SAMPLE_BITS-1:0] history [MAX_TAPS];
	logic [WIN_BITS-1:0]           window_reg;
	int unsigned                   taken;
	int unsigned                   block_half;
	avg_word_t                     due_words [$];

	initial begin
		mismatch_count = 0;
		words_pending  = 0;
	end

	function automatic int unsigned half_window(input logic [WIN_BITS-1:0] win);
		int unsigned taps;
		int unsigned top;
		top  = (MAX_TAPS % 2 == 0) ? MAX_TAPS - 1 : MAX_TAPS;
		taps = int'(win) | 1;
		if (taps < 3)
			taps = 3;
		if (taps > top)
			taps = top;
		return taps / 2;
	endfunction

	// Integer division in SystemVerilog truncates toward zero, as the filter does.
	function automatic logic signed [SAMPLE_BITS-1:0] window_mean(input int unsigned half);
		int sum;
		int taps;
		sum  = 0;
		taps = 2 * half + 1;
		for (int k = 0; k < taps && k < MAX_TAPS; k++)
			sum += history[k];
		return SAMPLE_BITS'(sum / taps);
	endfunction

	task automatic take_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
		int unsigned idx;
		int unsigned extra;
		int          k;
		avg_word_t   w;
		if (taken == 0)
			block_half = half_window(window_reg);
		idx = taken;
		for (k = MAX_TAPS - 1; k > 0; k--)
			history[k] = history[k-1];
		history[0] = s;
		if (taken < MAX_TAPS)
			taken++;
		w.final_res = 1'b0;
		if (idx >= block_half) begin
			w.average = (idx >= 2 * block_half) ? window_mean(block_half) : '0;
			due_words.push_back(w);
			extra = block_half;
		end else begin
			extra = last ? idx + 1 : 0;
		end
		if (last) begin
			// The tail of the block flushes as zero words, the last one flagged.
			w.average = '0;
			for (k = 0; k < extra; k++)
				due_words.push_back(w);
			due_words[$].final_res = 1'b1;
			taken = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		avg_word_t want;
		if (!arst_n) begin
			foreach (history[j])
				history[j] = '0;
			window_reg = WIN_RESET;
			taken      = 0;
			block_half = 1;
			due_words.delete();
		end else begin
			if (results.valid && results.ready) begin
				if (due_words.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: word with nothing due: average %0d final_res %0b",
							$time, results.average, results.final_res);
				end else begin
					want = due_words.pop_front();
					if (results.average !== want.average
							|| results.final_res !== want.final_res) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: expected average %0d final_res %0b, got %0d %0b",
								$time, want.average, want.final_res,
								results.average, results.final_res);
					end
				end
			end
			if (samples.valid && samples.ready)
				take_sample(samples.sample, samples.block_end);
			if (cfg_we)
				window_reg = cfg_wdata;
		end
		words_pending = due_words.size();
	end

endmodule

`default_nettype wire

// ===== tb/centered_moving_average_top_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none

module centered_moving_average_top_tb;
	import cma_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 30;
	localparam int DRAIN_CYCLES  = 40;
	localparam int LONG_HOLD     = 80;
	localparam int PHASE_ITEMS   = 14;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [WIN_BITS-1:0] cfg_wdata;
	logic                calm;
	logic                stall_req;
	int                  mismatch_count;
	int                  words_pending;

	cma_sample_if sample_ch ();
	cma_result_if result_ch ();

	centered_moving_average_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (sample_ch),
		.results   (result_ch)
	);

	cma_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.samples        (sample_ch),
		.results        (result_ch),
		.mismatch_count (mismatch_count),
		.words_pending  (words_pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("centered_moving_average_top_tb: done, errors");
		$finish;
	end

	// Output side: short random stalls, plus one long hold-off that backs the block up.
	initial begin : receiver
		bit stall_done;
		stall_done      = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req && !stall_done) begin
				stall_done = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3) - 1) @(negedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int flavor);
		logic signed [SAMPLE_BITS-1:0] v;
		v = SAMPLE_BITS'($urandom);
		case (flavor)
			1: v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			2: v = SAMPLE_BITS'($urandom_range(0, 16)) - 16'sd8;
			default: ;
		endcase
		return v;
	endfunction

	// Offers one sample and returns at the falling edge after it was taken, at times after a random gap with valid low.
	task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
		sample_ch.valid     <= 1'b1;
		sample_ch.sample    <= s;
		sample_ch.block_end <= last;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	task automatic set_window(input logic [WIN_BITS-1:0] w);
		sample_ch.valid <= 1'b0;
		while (words_pending != 0)
			@(negedge clk);
		// A sample that yields no word may still be in flight.
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wdata <= w;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_blocks(input int items);
		int n;
		int len;
		int flavor;
		int k;
		n = 0;
		while (n < items) begin
			len    = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
			flavor = $urandom_range(0, 3);
			for (k = 0; k < len; k++)
				push_sample(pick_sample(flavor), k == len - 1);
			n += len;
		end
	endtask

	initial begin : stimulus
		logic [WIN_BITS-1:0] windows [8];
		int                  p;
		windows = '{3'd0, 3'd5, 3'd2, 3'd6, 3'd4, 3'd1, 3'd7, 3'd3};
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		calm                = 1'b0;
		stall_req           = 1'b0;
		sample_ch.valid     = 1'b0;
		sample_ch.sample    = '0;
		sample_ch.block_end = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Three taps after reset: blocks shorter than the window, then full ones.
		push_sample(16'sh7fff, 1'b1);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sd1, 1'b1);
		repeat (2) push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh7fff, 1'b1);
		repeat (2) push_sample(16'sh8000, 1'b0);
		push_sample(16'sh8000, 1'b1);
		// Negative sums must truncate toward zero.
		push_sample(-16'sd1, 1'b0);
		push_sample(-16'sd1, 1'b0);
		push_sample(16'sd0, 1'b0);
		push_sample(16'sd5, 1'b1);
		push_sample(-16'sd5, 1'b0);
		push_sample(16'sd0, 1'b0);
		push_sample(16'sd0, 1'b1);
		// A window change in mid-block only applies from the next block on.
		push_sample(16'sd100, 1'b0);
		push_sample(-16'sd200, 1'b0);
		set_window(3'd7);
		push_sample(16'sd300, 1'b0);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh8000, 1'b1);
		repeat (6) push_sample(16'sh8000, 1'b0);
		push_sample(16'sh8000, 1'b1);

		stall_req <= 1'b1;
		for (p = 0; p < 8; p++) begin
			set_window(windows[p]);
			if (p == 7)
				calm <= 1'b1;
			run_blocks(PHASE_ITEMS);
		end

		sample_ch.valid <= 1'b0;
		while (words_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && words_pending == 0)
			$display("centered_moving_average_top_tb: done, clean");
		else
			$display("centered_moving_average_top_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
